### hdl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared widths, register indexes, ICT coefficients and pipeline types for
// the forward color transform.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int FRAC_BITS = 13;
  localparam int SAMPLE_W  = 17;
  localparam int SHIFT_W   = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  // coefficients are below one in magnitude: FRAC_BITS plus sign plus margin
  localparam int COEF_W    = FRAC_BITS + 2;
  localparam int PROD_W    = DATA_W + COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SHIFT_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SHIFT_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SHIFT_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REAL_MODE     = CFG_IDX_W'(4);

  localparam logic [MODE_W-1:0] MODE_BYPASS = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RCT    = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_ICT    = MODE_W'(2);

  localparam logic [SHIFT_W-1:0] LEVEL_SHIFT_RST = SHIFT_W'(128);

  // constants in units of 1e-5, truncated toward zero to FRAC_BITS
  localparam longint SCALE = longint'(1) << FRAC_BITS;
  localparam logic signed [COEF_W-1:0] C_Y_R = COEF_W'((29900 * SCALE) / 100000);
  localparam logic signed [COEF_W-1:0] C_Y_G = COEF_W'((58700 * SCALE) / 100000);
  localparam logic signed [COEF_W-1:0] C_Y_B = COEF_W'((11400 * SCALE) / 100000);
  localparam logic signed [COEF_W-1:0] C_U_R = COEF_W'(-((16875 * SCALE) / 100000));
  localparam logic signed [COEF_W-1:0] C_U_G = COEF_W'(-((33126 * SCALE) / 100000));
  localparam logic signed [COEF_W-1:0] C_U_B = COEF_W'((50000 * SCALE) / 100000);
  localparam logic signed [COEF_W-1:0] C_V_R = COEF_W'((50000 * SCALE) / 100000);
  localparam logic signed [COEF_W-1:0] C_V_G = COEF_W'(-((41869 * SCALE) / 100000));
  localparam logic signed [COEF_W-1:0] C_V_B = COEF_W'(-((8131 * SCALE) / 100000));

  localparam logic signed [COEF_W-1:0] COEF [3][3] = '{
    '{C_Y_R, C_Y_G, C_Y_B},
    '{C_U_R, C_U_G, C_U_B},
    '{C_V_R, C_V_G, C_V_B}
  };

  typedef struct packed {
    logic [SHIFT_W-1:0] level_shift_0;
    logic [SHIFT_W-1:0] level_shift_1;
    logic [SHIFT_W-1:0] level_shift_2;
    logic [MODE_W-1:0]  transform_mode;
    logic               real_mode;
  } cfg_t;

  typedef struct packed {
    logic ict;
    logic rct;
  } ctl_t;

  // component 0, 1, 2 after level shift and optional scaling
  typedef logic [2:0][DATA_W-1:0] pixel_t;

  // three addends per output channel
  typedef struct packed {
    logic [2:0][2:0][DATA_W-1:0] term;
    logic                        asr2;
  } terms_t;

endpackage

### hdl/fct_cfg_regs.sv
// ----------------------------------------------------------------------------
// fct_cfg_regs
// Configuration register file: level shifts, transform mode, real mode.
// ----------------------------------------------------------------------------
module fct_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fct_pkg::SHIFT_W-1:0]   cfg_data,
  output fct_pkg::cfg_t                 cfg
);
  import fct_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LEVEL_SHIFT_0: cfg_nxt.level_shift_0  = cfg_data;
        REG_LEVEL_SHIFT_1: cfg_nxt.level_shift_1  = cfg_data;
        REG_LEVEL_SHIFT_2: cfg_nxt.level_shift_2  = cfg_data;
        REG_TRANSFORM:     cfg_nxt.transform_mode = cfg_data[MODE_W-1:0];
        REG_REAL_MODE:     cfg_nxt.real_mode      = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_shift_0  <= LEVEL_SHIFT_RST;
      cfg_r.level_shift_1  <= LEVEL_SHIFT_RST;
      cfg_r.level_shift_2  <= LEVEL_SHIFT_RST;
      cfg_r.transform_mode <= MODE_RCT;
      cfg_r.real_mode      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/fct_shift_stage.sv
// ----------------------------------------------------------------------------
// fct_shift_stage
// Stage one: DC level shift, optional fixed-point scaling, mode decode.
// ----------------------------------------------------------------------------
module fct_shift_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [fct_pkg::SAMPLE_W-1:0] sample_red,
  input  logic [fct_pkg::SAMPLE_W-1:0] sample_green,
  input  logic [fct_pkg::SAMPLE_W-1:0] sample_blue,
  input  fct_pkg::cfg_t                cfg,
  output logic                         vld,
  output fct_pkg::pixel_t              pix,
  output fct_pkg::ctl_t                ctl
);
  import fct_pkg::*;

  logic                 vld_r;
  pixel_t               pix_r;
  pixel_t               pix_nxt;
  ctl_t                 ctl_r;
  ctl_t                 ctl_nxt;
  logic [2:0][SAMPLE_W-1:0] smp;
  logic [2:0][SHIFT_W-1:0]  lvl;
  logic [DIFF_W-1:0]    diff;
  logic [DATA_W-1:0]    ext;
  logic                 scale;

  assign smp = {sample_blue, sample_green, sample_red};
  assign lvl = {cfg.level_shift_2, cfg.level_shift_1, cfg.level_shift_0};

  always_comb begin
    ctl_nxt.ict = cfg.transform_mode[1];
    ctl_nxt.rct = (cfg.transform_mode == MODE_RCT);
    scale       = cfg.transform_mode[1] | cfg.real_mode;
    diff        = '0;
    ext         = '0;
    pix_nxt     = '0;
    for (int c = 0; c < 3; c++) begin
      diff = {smp[c][SAMPLE_W-1], smp[c]} - {{(DIFF_W-SHIFT_W){1'b0}}, lvl[c]};
      ext  = {{(DATA_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      pix_nxt[c] = scale ? (ext << FRAC_BITS) : ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign vld = vld_r;
  assign pix = pix_r;
  assign ctl = ctl_r;

endmodule

### hdl/fct_mult_stage.sv
// ----------------------------------------------------------------------------
// fct_mult_stage
// Stage two: the nine ICT products, or the RCT / bypass addends.
// ----------------------------------------------------------------------------
module fct_mult_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  fct_pkg::pixel_t pix,
  input  fct_pkg::ctl_t   ctl,
  output logic            vld,
  output fct_pkg::terms_t terms
);
  import fct_pkg::*;

  logic   vld_r;
  terms_t terms_r;
  terms_t terms_nxt;

  // exact product, arithmetic shift right, keep low word
  function automatic logic [DATA_W-1:0] mul_shift(input logic signed [COEF_W-1:0] coef,
                                                  input logic signed [DATA_W-1:0] x);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] s;
    p = coef * x;
    s = p >>> FRAC_BITS;
    return s[DATA_W-1:0];
  endfunction

  always_comb begin
    terms_nxt      = '0;
    terms_nxt.asr2 = ~ctl.ict & ctl.rct;
    if (ctl.ict) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          terms_nxt.term[i][j] = mul_shift(COEF[i][j], pix[j]);
        end
      end
    end else if (ctl.rct) begin
      terms_nxt.term[0][0] = pix[0];
      terms_nxt.term[0][1] = pix[1] << 1;
      terms_nxt.term[0][2] = pix[2];
      terms_nxt.term[1][0] = pix[2];
      terms_nxt.term[1][1] = DATA_W'(0) - pix[1];
      terms_nxt.term[2][0] = pix[0];
      terms_nxt.term[2][1] = DATA_W'(0) - pix[1];
    end else begin
      terms_nxt.term[0][0] = pix[0];
      terms_nxt.term[1][0] = pix[1];
      terms_nxt.term[2][0] = pix[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

  assign vld   = vld_r;
  assign terms = terms_r;

endmodule

### hdl/fct_sum_stage.sv
// ----------------------------------------------------------------------------
// fct_sum_stage
// Stage three: add the three terms of each channel, RCT luma shift, output
// register.
// ----------------------------------------------------------------------------
module fct_sum_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_in,
  input  fct_pkg::terms_t            terms,
  output logic                       vld,
  output logic [fct_pkg::DATA_W-1:0] luma,
  output logic [fct_pkg::DATA_W-1:0] chroma_b,
  output logic [fct_pkg::DATA_W-1:0] chroma_r
);
  import fct_pkg::*;

  logic                     vld_r;
  logic [2:0][DATA_W-1:0]   res_r;
  logic [2:0][DATA_W-1:0]   res_nxt;
  logic signed [DATA_W-1:0] sum;

  always_comb begin
    res_nxt = '0;
    sum     = '0;
    for (int i = 0; i < 3; i++) begin
      sum = terms.term[i][0] + terms.term[i][1] + terms.term[i][2];
      res_nxt[i] = (i == 0 && terms.asr2) ? DATA_W'(sum >>> 2) : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign vld      = vld_r;
  assign luma     = res_r[0];
  assign chroma_b = res_r[1];
  assign chroma_r = res_r[2];

endmodule

### hdl/jpeg2000_forward_color_transform.sv
// ----------------------------------------------------------------------------
// jpeg2000_forward_color_transform
// Forward component transform (bypass, RCT, ICT) with DC level shift.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one three-component pixel per request.
//   Output channel out_*: one transformed pixel per request, 32-bit wrap.
//   Config channel cfg_*: register index and data; always ready. Write only
//   while no pixel is in flight.
// Timing:
//   Three register stages (level shift / multiply / sum). A pixel accepted at
//   the input is registered by the shift, multiply and sum stages in turn
//   before it shows on out_*. One pixel per cycle sustained while out_ready
//   holds high; the nine ICT multipliers all sit in the multiply stage.
// Reset:
//   rst_n low clears all valid bits and loads level shifts 128, RCT mode,
//   real mode off.
// Stall:
//   When out_ready is low with a result waiting, the whole pipe holds and
//   in_ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module jpeg2000_forward_color_transform (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fct_pkg::SHIFT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fct_pkg::SAMPLE_W-1:0]  in_sample_red,
  input  logic [fct_pkg::SAMPLE_W-1:0]  in_sample_green,
  input  logic [fct_pkg::SAMPLE_W-1:0]  in_sample_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fct_pkg::DATA_W-1:0]    out_luma_out,
  output logic [fct_pkg::DATA_W-1:0]    out_chroma_b_out,
  output logic [fct_pkg::DATA_W-1:0]    out_chroma_r_out
);
  import fct_pkg::*;

  cfg_t   cfg;
  logic   en;
  logic   s1_vld;
  pixel_t s1_pix;
  ctl_t   s1_ctl;
  logic   s2_vld;
  terms_t s2_terms;

  // pipe advances whenever the output slot is empty or being drained
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  fct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fct_shift_stage u_shift (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_in       (in_valid),
    .sample_red   (in_sample_red),
    .sample_green (in_sample_green),
    .sample_blue  (in_sample_blue),
    .cfg          (cfg),
    .vld          (s1_vld),
    .pix          (s1_pix),
    .ctl          (s1_ctl)
  );

  fct_mult_stage u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_in (s1_vld),
    .pix    (s1_pix),
    .ctl    (s1_ctl),
    .vld    (s2_vld),
    .terms  (s2_terms)
  );

  fct_sum_stage u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (s2_vld),
    .terms    (s2_terms),
    .vld      (out_valid),
    .luma     (out_luma_out),
    .chroma_b (out_chroma_b_out),
    .chroma_r (out_chroma_r_out)
  );

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld && en) |=> s2_vld)
    else $error("stage one request dropped");

  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld && en) |=> out_valid)
    else $error("stage two request dropped");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=>
      ($countones({s1_vld, s2_vld, out_valid}) <=
       $past($countones({s1_vld, s2_vld, out_valid}))))
    else $error("request appeared in pipe without input");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s1_vld) && $stable(s2_vld)))
    else $error("inner stage moved during stall");

endmodule

### dv/jpeg2000_forward_color_transform_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jpeg2000_forward_color_transform_tb
// Self-checking bench for the forward color transform. Pixels go in over the
// in_* channel and each result on out_* is checked field by field against an
// in-order prediction of bypass, RCT and ICT with level shift and scaling.
// Covers register writes between phases, random idling on both sides and a
// long output hold that backs the pipe up into the input.
// ----------------------------------------------------------------------------
module jpeg2000_forward_color_transform_tb;
  import fct_pkg::*;

  localparam int FRAC = FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_REAL_MODE + CFG_IDX_W'(1);
  localparam logic [MODE_W-1:0] MODE_ICT_ALT = MODE_ICT | MODE_RCT;

  // ICT constants in units of 1e-5
  localparam longint K_Y_R = 29900;
  localparam longint K_Y_G = 58700;
  localparam longint K_Y_B = 11400;
  localparam longint K_U_R = -16875;
  localparam longint K_U_G = -33126;
  localparam longint K_U_B = 50000;
  localparam longint K_V_R = 50000;
  localparam longint K_V_G = -41869;
  localparam longint K_V_B = -8131;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 17'h0FFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 17'h10000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1 = 17'h1FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] luma;
    logic [DATA_W-1:0] chroma_b;
    logic [DATA_W-1:0] chroma_r;
  } ycc_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SHIFT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] in_sample_red = '0;
  logic [SAMPLE_W-1:0] in_sample_green = '0;
  logic [SAMPLE_W-1:0] in_sample_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DATA_W-1:0] out_luma_out;
  logic [DATA_W-1:0] out_chroma_b_out;
  logic [DATA_W-1:0] out_chroma_r_out;

  // shadow of the block's registers
  logic [SHIFT_W-1:0] shift_reg [3] = '{LEVEL_SHIFT_RST, LEVEL_SHIFT_RST, LEVEL_SHIFT_RST};
  logic [MODE_W-1:0] mode_reg = MODE_RCT;
  logic real_reg = 1'b0;

  ycc_t transformed_q [$];
  ycc_t ycc_want;
  int mismatch_count = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_stall_left = 0;
  int rx_hold_left = 0;

  jpeg2000_forward_color_transform dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_red    (in_sample_red),
    .in_sample_green  (in_sample_green),
    .in_sample_blue   (in_sample_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma_out     (out_luma_out),
    .out_chroma_b_out (out_chroma_b_out),
    .out_chroma_r_out (out_chroma_r_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("jpeg2000_forward_color_transform_tb: errors");
    $finish;
  end

  // coefficient truncated toward zero, exact 64-bit product, then wrap
  function automatic logic [DATA_W-1:0] fixed_mul(longint c5, logic [DATA_W-1:0] x);
    longint coef;
    longint prod;
    coef = (((c5 < 0) ? -c5 : c5) << FRAC) / 100000;
    if (c5 < 0) coef = -coef;
    prod = coef * longint'($signed(x));
    return DATA_W'(prod >>> FRAC);
  endfunction

  function automatic ycc_t color_transform(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] green,
                                           logic [SAMPLE_W-1:0] blue);
    logic [DATA_W-1:0] r, g, b;
    ycc_t res;
    r = {{(DATA_W-SAMPLE_W){red[SAMPLE_W-1]}}, red} - DATA_W'(shift_reg[0]);
    g = {{(DATA_W-SAMPLE_W){green[SAMPLE_W-1]}}, green} - DATA_W'(shift_reg[1]);
    b = {{(DATA_W-SAMPLE_W){blue[SAMPLE_W-1]}}, blue} - DATA_W'(shift_reg[2]);
    // ICT is decoded from the upper mode bit only and always scales
    if (mode_reg[1] || real_reg) begin
      r = r << FRAC;
      g = g << FRAC;
      b = b << FRAC;
    end
    if (mode_reg[1]) begin
      res.luma     = fixed_mul(K_Y_R, r) + fixed_mul(K_Y_G, g) + fixed_mul(K_Y_B, b);
      res.chroma_b = fixed_mul(K_U_R, r) + fixed_mul(K_U_G, g) + fixed_mul(K_U_B, b);
      res.chroma_r = fixed_mul(K_V_R, r) + fixed_mul(K_V_G, g) + fixed_mul(K_V_B, b);
    end else if (mode_reg == MODE_RCT) begin
      res.luma     = DATA_W'($signed(r + (g << 1) + b) >>> 2);
      res.chroma_b = b - g;
      res.chroma_r = r - g;
    end else begin
      res.luma     = r;
      res.chroma_b = g;
      res.chroma_r = b;
    end
    return res;
  endfunction

  // receiver: random short stalls, plus a long hold when a test asks for one
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic note_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (transformed_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request outstanding: %h %h %h", $realtime,
                   out_luma_out, out_chroma_b_out, out_chroma_r_out);
      end else begin
        ycc_want = transformed_q.pop_front();
        if (out_luma_out !== ycc_want.luma)
          note_mismatch("luma", ycc_want.luma, out_luma_out);
        if (out_chroma_b_out !== ycc_want.chroma_b)
          note_mismatch("chroma_b", ycc_want.chroma_b, out_chroma_b_out);
        if (out_chroma_r_out !== ycc_want.chroma_r)
          note_mismatch("chroma_r", ycc_want.chroma_r, out_chroma_r_out);
      end
    end
  end

  // valid stays high across back-to-back requests; only a gap or drain() lowers it
  task automatic send_pixel(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] green,
                            logic [SAMPLE_W-1:0] blue);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_red   <= red;
    in_sample_green <= green;
    in_sample_blue  <= blue;
    do @(posedge clk); while (!in_ready);
    transformed_q.push_back(color_transform(red, green, blue));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SHIFT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEVEL_SHIFT_0: shift_reg[0] = data;
      REG_LEVEL_SHIFT_1: shift_reg[1] = data;
      REG_LEVEL_SHIFT_2: shift_reg[2] = data;
      REG_TRANSFORM:     mode_reg = data[MODE_W-1:0];
      REG_REAL_MODE:     real_reg = data[0];
      default: ;
    endcase
  endtask

  // upper data bits are don't-care for the narrow registers: keep them random
  task automatic apply_config(logic [SHIFT_W-1:0] ls0, logic [SHIFT_W-1:0] ls1,
                              logic [SHIFT_W-1:0] ls2, logic [MODE_W-1:0] mode, logic real_on);
    drain();
    write_reg(REG_LEVEL_SHIFT_0, ls0);
    write_reg(REG_LEVEL_SHIFT_1, ls1);
    write_reg(REG_LEVEL_SHIFT_2, ls2);
    write_reg(REG_TRANSFORM, {(SHIFT_W-MODE_W)'($urandom), mode});
    write_reg(REG_REAL_MODE, {(SHIFT_W-1)'($urandom), real_on});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_corners();
    send_pixel('0, '0, '0);
    send_pixel(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_pixel(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    send_pixel(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_NEG1);
    drain();
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return SHIFT_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_state();
    send_corners();
  endtask

  task automatic test_bypass();
    apply_config('0, '0, '0, MODE_BYPASS, 1'b0);
    send_corners();
  endtask

  task automatic test_rct_scaled();
    apply_config(16'hFFFF, 16'h8000, '0, MODE_RCT, 1'b1);
    send_corners();
  endtask

  task automatic test_ict();
    // real mode off has no effect here
    apply_config(16'h8000, 16'h8000, 16'h8000, MODE_ICT, 1'b0);
    send_corners();
  endtask

  task automatic test_mode_three();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_ICT_ALT, 1'b1);
    send_corners();
  endtask

  task automatic test_spare_index();
    logic [CFG_IDX_W-1:0] idx;
    apply_config(16'h0123, 16'h4567, 16'h89AB, MODE_RCT, 1'b0);
    for (idx = REG_SPARE; idx != '0; idx++)
      write_reg(idx, SHIFT_W'($urandom));
    cfg_valid <= 1'b0;
    send_pixel(SAMPLE_NEG1, 17'h00001, SAMPLE_MAX);
    send_pixel(pick_sample(), pick_sample(), pick_sample());
    drain();
  endtask

  task automatic test_backpressure();
    apply_config(pick_shift(), pick_shift(), pick_shift(), MODE_ICT, 1'b0);
    tx_gaps_on = 1'b0;
    rx_hold_left = 60;
    repeat (40) send_pixel(pick_sample(), pick_sample(), pick_sample());
    drain();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 13; phase++) begin
      apply_config(pick_shift(), pick_shift(), pick_shift(),
                   MODE_W'($urandom_range(0, 3)), 1'($urandom));
      // last phase runs flat out on both sides
      tx_gaps_on   = (phase < 12) && ($urandom_range(0, 3) != 0);
      rx_stalls_on = (phase < 12) && ($urandom_range(0, 3) != 0);
      repeat (145) send_pixel(pick_sample(), pick_sample(), pick_sample());
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_bypass();
    test_rct_scaled();
    test_ict();
    test_mode_three();
    test_spare_index();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && transformed_q.size() == 0)
      $display("jpeg2000_forward_color_transform_tb: clean");
    else
      $display("jpeg2000_forward_color_transform_tb: errors");
    $finish;
  end

endmodule
